// ===== src/ccr_pkg.sv =====
// Shared types, constants and helpers for the circle canvas rasterizer.
// No dependencies; imported by every module of the block.
package ccr_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int FRAC_BITS      = 8;

    localparam int COORD_W = 20;
    localparam int SIZE_W  = 10;
    localparam int POS_W   = 9;
    localparam int CHAR_W  = 8;
    localparam int DIFF_W  = SIZE_W + FRAC_BITS > COORD_W ?
                             SIZE_W + FRAC_BITS + 2 : COORD_W + 1;
    localparam int ABS_W   = DIFF_W - 1;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int RSQ_W   = 2 * COORD_W;
    localparam int LIN_W   = 2 * SIZE_W;

    localparam int PADDR_W = 4;
    localparam int APB_W   = 32;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 8;

    localparam logic [COORD_W-1:0] FIX_ONE = COORD_W'(1) << FRAC_BITS;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_DRAW  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               clear;
        logic               filled;
        logic               thin;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [RSQ_W-1:0]   r2;
        logic [RSQ_W-1:0]   ri2;
        logic [CHAR_W-1:0]  ch;
    } t_draw_job;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [APB_W-1:0] v,
                                                     input int maxv);
        logic [SIZE_W-1:0] x;
        x = v[SIZE_W-1:0];
        if (x == '0) begin
            x = SIZE_W'(1);
        end
        if (int'(x) > maxv) begin
            x = SIZE_W'(maxv);
        end
        return x;
    endfunction

endpackage

// ===== src/circle_canvas_rasterizer_core.sv =====
// Circle canvas rasterizer: character canvas store with clear, circle draw
// and pixel read. Depends on ccr_pkg and ccr_pixel_pipe.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser req_type; tdata request fields
//  m_axis    out  tvalid/tready          tuser status; tdata pixel_char
//  apb       in   psel/penable/pready    width, height, background char
//
// Clear and draw sweep the canvas at one pixel per cycle through the single
// memory write port; draw first passes a setup step. Read goes through the
// address multiply, the memory read and the result load.
// Reset sets width/height 512 and background 32; canvas contents are undefined
// until a clear or draw writes them. A result waits in the output register
// while the next request is taken; a finished job holds until that register frees.
module circle_canvas_rasterizer_core #(
    parameter int MAX_WIDTH  = ccr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ccr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ccr_pkg::PADDR_W-1:0]     paddr,
    input  logic [ccr_pkg::APB_W-1:0]       pwdata,
    output logic [ccr_pkg::APB_W-1:0]       prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // fill_mode[0], center_x[20:1], center_y[40:21], radius[60:41],
    // draw_char[68:61], pixel_col[77:69], pixel_row[86:78], zero[87]
    input  logic [ccr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_char[7:0]
    output logic [ccr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[0]
    output logic [0:0]                      m_axis_tuser
);
    import ccr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;

    logic [SIZE_W-1:0] r_width, r_height;
    logic [CHAR_W-1:0] r_bg;

    logic [1:0]         r_req;
    logic               r_fill, r_thin, r_clear, r_status;
    logic [COORD_W-1:0] r_cx, r_cy, r_rad;
    logic [CHAR_W-1:0]  r_char;
    logic [POS_W-1:0]   r_pcol, r_prow;
    logic [RSQ_W-1:0]   r_r2, r_ri2;

    logic [SIZE_W-1:0] r_col, r_row;
    logic [AW-1:0]     r_addr, r_raddr;

    logic               r_out_valid, r_out_status;
    logic [CHAR_W-1:0]  r_out_char, r_rd_data;
    logic [CHAR_W-1:0]  r_canvas [DEPTH];

    logic               in_fill;
    logic [COORD_W-1:0] in_cx, in_cy, in_rad;
    logic [CHAR_W-1:0]  in_char;
    logic [POS_W-1:0]   in_pcol, in_prow;

    logic               accept, cfg_wr, scan_last, out_free, load_out;
    logic               pipe_we, pipe_busy;
    logic [AW-1:0]      pipe_waddr;
    logic [CHAR_W-1:0]  pipe_wdata;
    logic [LIN_W-1:0]   rd_lin;
    logic [COORD_W-1:0] ri;
    t_draw_job          job;

    assign in_fill = s_axis_tdata[0];
    assign in_cx   = s_axis_tdata[20:1];
    assign in_cy   = s_axis_tdata[40:21];
    assign in_rad  = s_axis_tdata[60:41];
    assign in_char = s_axis_tdata[68:61];
    assign in_pcol = s_axis_tdata[77:69];
    assign in_prow = s_axis_tdata[86:78];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = APB_W'(r_width);
            REG_HEIGHT: prdata = APB_W'(r_height);
            REG_BG:     prdata = APB_W'(r_bg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_size(APB_W'(DEF_MAX_WIDTH), MAX_WIDTH);
            r_height <= clamp_size(APB_W'(DEF_MAX_HEIGHT), MAX_HEIGHT);
            r_bg     <= CHAR_W'(32);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= clamp_size(pwdata, MAX_WIDTH);
                REG_HEIGHT: r_height <= clamp_size(pwdata, MAX_HEIGHT);
                REG_BG:     r_bg     <= pwdata[CHAR_W-1:0];
                default:    ;
            endcase
        end
    end

    // control
    assign scan_last = (r_col == r_width - SIZE_W'(1)) && (r_row == r_height - SIZE_W'(1));
    assign out_free  = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        REQ_CLEAR: n_state = ST_SCAN;
                        REQ_DRAW:  n_state = (in_rad == '0) ? ST_DONE : ST_SETUP;
                        REQ_READ: begin
                            if ({1'b0, in_pcol} >= r_width || {1'b0, in_prow} >= r_height) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_RD_ADDR;
                            end
                        end
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_SETUP:   n_state = ST_SCAN;
            ST_SCAN:    if (scan_last) n_state = ST_DRAIN;
            ST_DRAIN:   if (!pipe_busy) n_state = ST_DONE;
            ST_RD_ADDR: n_state = ST_RD_MEM;
            ST_RD_MEM:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request fields and scan counters
    assign ri = r_thin ? '0 : r_rad - FIX_ONE;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= s_axis_tuser;
            r_fill   <= in_fill;
            r_cx     <= in_cx;
            r_cy     <= in_cy;
            r_rad    <= in_rad;
            r_char   <= in_char;
            r_pcol   <= in_pcol;
            r_prow   <= in_prow;
            r_thin   <= in_rad <= FIX_ONE;
            r_clear  <= s_axis_tuser == REQ_CLEAR;
            r_status <= (s_axis_tuser == REQ_DRAW && in_rad == '0) ||
                        (s_axis_tuser == REQ_READ &&
                         ({1'b0, in_pcol} >= r_width || {1'b0, in_prow} >= r_height));
            r_col    <= '0;
            r_row    <= '0;
            r_addr   <= '0;
        end else if (r_state == ST_SCAN) begin
            r_addr <= r_addr + AW'(1);
            if (r_col == r_width - SIZE_W'(1)) begin
                r_col <= '0;
                r_row <= r_row + SIZE_W'(1);
            end else begin
                r_col <= r_col + SIZE_W'(1);
            end
        end
        if (r_state == ST_SETUP) begin
            r_r2  <= r_rad * r_rad;
            r_ri2 <= ri * ri;
        end
    end

    assign job = '{
        clear:  r_clear,
        filled: r_fill,
        thin:   r_thin,
        cx:     r_cx,
        cy:     r_cy,
        r2:     r_r2,
        ri2:    r_ri2,
        ch:     r_clear ? r_bg : r_char
    };

    ccr_pixel_pipe #(
        .AW(AW)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == ST_SCAN),
        .i_col   (r_col),
        .i_row   (r_row),
        .i_addr  (r_addr),
        .i_job   (job),
        .o_we    (pipe_we),
        .o_waddr (pipe_waddr),
        .o_wdata (pipe_wdata),
        .o_busy  (pipe_busy)
    );

    // canvas store
    assign rd_lin = LIN_W'(r_prow) * LIN_W'(r_width) + LIN_W'(r_pcol);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD_ADDR) begin
            r_raddr <= AW'(rd_lin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_we) begin
            r_canvas[pipe_waddr] <= pipe_wdata;
        end
        r_rd_data <= r_canvas[r_raddr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_status;
            r_out_char   <= (r_req == REQ_READ && !r_status) ? r_rd_data : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = r_out_status;

endmodule

// ===== src/ccr_pixel_pipe.sv =====
// Per-pixel distance pipeline: offsets, squares, circle and outline test.
// Depends on ccr_pkg; drives the canvas write port of the top level.
module ccr_pixel_pipe #(
    parameter int AW = 18
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [ccr_pkg::SIZE_W-1:0] i_col,
    input  logic [ccr_pkg::SIZE_W-1:0] i_row,
    input  logic [AW-1:0]             i_addr,
    input  ccr_pkg::t_draw_job        i_job,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [ccr_pkg::CHAR_W-1:0] o_wdata,
    output logic                      o_busy
);
    import ccr_pkg::*;

    logic signed [DIFF_W-1:0] dx, dy;
    logic [ABS_W-1:0] adx, ady;
    logic [DIST_W-1:0] d2;
    logic hit;

    logic              r1_valid, r2_valid;
    logic [ABS_W-1:0]  r1_adx, r1_ady;
    logic [AW-1:0]     r1_addr, r2_addr;
    logic [SQ_W-1:0]   r2_dx2, r2_dy2;

    always_comb begin
        dx = $signed(DIFF_W'({i_col, {FRAC_BITS{1'b0}}})) -
             $signed(DIFF_W'($signed(i_job.cx)));
        dy = $signed(DIFF_W'({i_row, {FRAC_BITS{1'b0}}})) -
             $signed(DIFF_W'($signed(i_job.cy)));
        adx = dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
        ady = dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_adx  <= adx;
        r1_ady  <= ady;
        r1_addr <= i_addr;
        r2_dx2  <= r1_adx * r1_adx;
        r2_dy2  <= r1_ady * r1_ady;
        r2_addr <= r1_addr;
    end

    always_comb begin
        d2  = DIST_W'(r2_dx2) + DIST_W'(r2_dy2);
        hit = (d2 <= DIST_W'(i_job.r2)) &&
              (i_job.filled || i_job.thin || d2 > DIST_W'(i_job.ri2));
    end

    assign o_we    = r2_valid && (i_job.clear || hit);
    assign o_waddr = r2_addr;
    assign o_wdata = i_job.ch;
    assign o_busy  = r1_valid || r2_valid;

endmodule

// ===== dv/circle_canvas_rasterizer_core_tb.sv =====
// Self-checking testbench for circle_canvas_rasterizer_core: clear, circle draw and pixel read
// requests over the stream ports, canvas setup over APB, results checked against a local
// canvas model. Depends on ccr_pkg and the core RTL.
module circle_canvas_rasterizer_core_tb;
    import ccr_pkg::*;

    localparam logic [1:0] REQ_NONE  = 2'd3;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CANVAS_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int FIX          = 1 << FRAC_BITS;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [1:0]         kind;
        logic               fill;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] rad;
        logic [CHAR_W-1:0]  ch;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        bit                 drain;
    } t_canvas_req;

    typedef struct {
        logic [CHAR_W-1:0] pixel_char;
        logic              status;
    } t_canvas_resp;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [APB_W-1:0]       pwdata = '0;
    logic [APB_W-1:0]       prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // fill_mode, center_x, center_y, radius, draw_char, pixel_col, pixel_row, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // req_type
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // pixel_char
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status
    logic [0:0]             m_axis_tuser;

    circle_canvas_rasterizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    logic [CHAR_W-1:0] canvas_mem [0:CANVAS_DEPTH-1];
    int                cfg_width;
    int                cfg_height;
    logic [CHAR_W-1:0] cfg_bg;

    t_canvas_req  pending_q [$];
    t_canvas_resp expected_q [$];
    t_canvas_req  in_flight;
    t_canvas_resp want;
    logic         launch;
    int           src_idle_pct = 20;
    int           sink_idle_pct = 57;
    int           errors = 0;
    int           cycles = 0;

    function automatic int size_hold(input logic [APB_W-1:0] v, input int maxv);
        int x;
        x = int'(v[SIZE_W-1:0]);
        if (x == 0) begin
            x = 1;
        end
        if (x > maxv) begin
            x = maxv;
        end
        return x;
    endfunction

    // Applies one request to the canvas copy and returns the response it should produce.
    function automatic t_canvas_resp rasterize(input t_canvas_req rq);
        t_canvas_resp rs;
        longint cxs, cys, rl, r2, ri2, dx, dy, d2;
        bit thin;
        rs.pixel_char = '0;
        rs.status = 1'b0;
        case (rq.kind)
            REQ_CLEAR: begin
                for (int i = 0; i < cfg_width * cfg_height; i++) begin
                    canvas_mem[i] = cfg_bg;
                end
            end
            REQ_DRAW: begin
                if (rq.rad == '0) begin
                    rs.status = 1'b1;
                end else begin
                    cxs  = longint'($signed(rq.cx));
                    cys  = longint'($signed(rq.cy));
                    rl   = longint'(rq.rad);
                    r2   = rl * rl;
                    thin = (rl <= FIX);
                    ri2  = thin ? 0 : (rl - FIX) * (rl - FIX);
                    for (int row = 0; row < cfg_height; row++) begin
                        dy = longint'(row) * FIX - cys;
                        for (int col = 0; col < cfg_width; col++) begin
                            dx = longint'(col) * FIX - cxs;
                            d2 = dy * dy + dx * dx;
                            if (d2 <= r2 && (rq.fill || thin || d2 > ri2)) begin
                                canvas_mem[row * cfg_width + col] = rq.ch;
                            end
                        end
                    end
                end
            end
            REQ_READ: begin
                if (int'(rq.col) >= cfg_width || int'(rq.row) >= cfg_height) begin
                    rs.status = 1'b1;
                end else begin
                    rs.pixel_char = canvas_mem[int'(rq.row) * cfg_width + int'(rq.col)];
                end
            end
            default: begin
            end
        endcase
        return rs;
    endfunction

    function automatic t_canvas_req rnd_req();
        t_canvas_req rq;
        rq.kind  = 2'($urandom_range(0, 3));
        rq.fill  = 1'($urandom_range(0, 1));
        rq.cx    = COORD_W'($urandom());
        rq.cy    = COORD_W'($urandom());
        rq.rad   = COORD_W'($urandom());
        rq.ch    = CHAR_W'($urandom());
        rq.col   = POS_W'($urandom());
        rq.row   = POS_W'($urandom());
        rq.drain = 1'b0;
        return rq;
    endfunction

    // Circles mostly near the canvas, with radii mostly of canvas scale; reads mostly in bounds.
    function automatic t_canvas_req random_item();
        t_canvas_req rq;
        int pick, span, rsel;
        rq   = rnd_req();
        pick = $urandom_range(0, 99);
        span = (cfg_width > cfg_height) ? cfg_width : cfg_height;
        if (pick < 8) begin
            rq.kind = REQ_CLEAR;
        end else if (pick < 52) begin
            rq.kind = REQ_DRAW;
            if ($urandom_range(0, 9) < 6) begin
                rq.cx = COORD_W'(int'($urandom_range(0, (cfg_width + 8) * FIX)) - 4 * FIX);
                rq.cy = COORD_W'(int'($urandom_range(0, (cfg_height + 8) * FIX)) - 4 * FIX);
            end
            rsel = $urandom_range(0, 19);
            if (rsel < 10) begin
                rq.rad = COORD_W'($urandom_range(1, (span / 2 + 2) * FIX));
            end else if (rsel < 13) begin
                rq.rad = COORD_W'($urandom_range(0, 300));
            end else if (rsel < 16) begin
                rq.rad = COORD_W'($urandom_range(FIX, span * FIX));
            end
        end else if (pick < 94) begin
            rq.kind = REQ_READ;
            if ($urandom_range(0, 9) < 8) begin
                rq.col = POS_W'($urandom_range(0, cfg_width - 1));
                rq.row = POS_W'($urandom_range(0, cfg_height - 1));
            end
        end else begin
            rq.kind = REQ_NONE;
        end
        rq.drain = ($urandom_range(0, 99) < 4);
        return rq;
    endfunction

    task automatic push_clear();
        t_canvas_req rq;
        rq = rnd_req();
        rq.kind = REQ_CLEAR;
        pending_q.push_back(rq);
    endtask

    task automatic push_draw(input logic fill, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] rad,
                             input logic [CHAR_W-1:0] ch);
        t_canvas_req rq;
        rq = rnd_req();
        rq.kind = REQ_DRAW;
        rq.fill = fill;
        rq.cx   = cx;
        rq.cy   = cy;
        rq.rad  = rad;
        rq.ch   = ch;
        pending_q.push_back(rq);
    endtask

    task automatic push_read(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
        t_canvas_req rq;
        rq = rnd_req();
        rq.kind = REQ_READ;
        rq.col  = col;
        rq.row  = row;
        pending_q.push_back(rq);
    endtask

    task automatic push_kind(input logic [1:0] kind);
        t_canvas_req rq;
        rq = rnd_req();
        rq.kind = kind;
        pending_q.push_back(rq);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [APB_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = size_hold(data, DEF_MAX_WIDTH);
            REG_HEIGHT: cfg_height = size_hold(data, DEF_MAX_HEIGHT);
            REG_BG:     cfg_bg     = data[CHAR_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Sampled at the falling edge so queue and valid updates of the rising edge have settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [APB_W-1:0] pick_size(input bit allow_big);
        logic [APB_W-1:0] v;
        int sel;
        v   = $urandom() & 32'hFFFF_FC00;
        sel = $urandom_range(0, 9);
        if (sel == 1 && allow_big) begin
            v = v | APB_W'($urandom_range(512, 1023));
        end else if (sel != 0) begin
            v = v | APB_W'($urandom_range(1, 48));
        end
        return v;
    endfunction

    task automatic run_random_phase(input int src_pct, input int sink_pct, input int n,
                                    input int hold_at);
        logic [APB_W-1:0] wv, hv;
        t_canvas_req rq;
        wait_idle();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        wv = pick_size(1'b1);
        if (size_hold(wv, DEF_MAX_WIDTH) > 64) begin
            hv = ($urandom() & 32'hFFFF_FC00) | APB_W'($urandom_range(1, 4));
        end else begin
            hv = pick_size(size_hold(wv, DEF_MAX_WIDTH) <= 8);
        end
        apb_write(REG_WIDTH, wv);
        apb_write(REG_HEIGHT, hv);
        apb_write(REG_BG, $urandom());
        push_clear();
        for (int i = 0; i < n; i++) begin
            rq = random_item();
            if (i == hold_at) begin
                rq.drain = 1'b1;
            end
            pending_q.push_back(rq);
        end
    endtask

    // Request driver; a drain item is held back until every response is in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(rasterize(in_flight));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                launch = 1'b0;
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    if (!pending_q[0].drain || expected_q.size() == 0) begin
                        launch = 1'b1;
                    end
                end
                if (launch) begin
                    in_flight = pending_q.pop_front();
                    s_axis_tdata <= {1'b0, in_flight.row, in_flight.col, in_flight.ch,
                                     in_flight.rad, in_flight.cy, in_flight.cx, in_flight.fill};
                    s_axis_tuser  <= in_flight.kind;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("unexpected transfer: pixel_char %02h status %0b",
                             m_axis_tdata, m_axis_tuser[0]);
                end
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (want.pixel_char !== m_axis_tdata || want.status !== m_axis_tuser[0]) begin
                    if (errors < MAX_REPORTS) begin
                        $display("mismatch: expected pixel_char %02h status %0b, got %02h %0b",
                                 want.pixel_char, want.status, m_axis_tdata, m_axis_tuser[0]);
                    end
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("circle_canvas_rasterizer_core_tb: errors");
            $finish;
        end
    end

    initial begin
        cfg_width  = DEF_MAX_WIDTH;
        cfg_height = DEF_MAX_HEIGHT;
        cfg_bg     = 8'd32;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-size canvas at reset values
        push_clear();
        push_read(9'd0, 9'd0);
        push_read(9'd511, 9'd511);

        // width written as zero, height above max
        wait_idle();
        apb_write(REG_WIDTH, 32'h0000_0000);
        apb_write(REG_HEIGHT, 32'hFFFF_FFFF);
        apb_write(REG_BG, 32'hFFFF_FFFF);
        push_clear();
        push_draw(1'b1, 20'd0, COORD_W'(256 * FIX), COORD_W'(10 * FIX), "C");
        push_read(9'd0, 9'd256);
        push_read(9'd1, 9'd0);

        // single row at max width
        wait_idle();
        apb_write(REG_WIDTH, 32'h0000_03FF);
        apb_write(REG_HEIGHT, 32'h0000_0400);
        apb_write(REG_BG, 32'h0000_0000);
        push_clear();
        push_draw(1'b0, COORD_W'(300 * FIX), 20'd0, COORD_W'(20 * FIX), "c");
        push_read(9'd280, 9'd0);
        push_read(9'd0, 9'd1);

        wait_idle();
        apb_write(REG_WIDTH, 32'd16);
        apb_write(REG_HEIGHT, 32'd12);
        apb_write(REG_BG, 32'h0000_002E);
        apb_write(REG_SPARE, $urandom());
        push_clear();
        push_draw(1'b1, 20'h7FFFF, 20'h7FFFF, 20'hFFFFF, 8'hFF);
        push_draw(1'b0, 20'h80000, 20'h80000, 20'hFFFFF, 8'h00);
        push_draw(1'b1, COORD_W'(5 * FIX), COORD_W'(5 * FIX), 20'd0, "x");
        push_draw(1'b0, COORD_W'(5 * FIX), COORD_W'(5 * FIX), COORD_W'(FIX), "c");
        push_draw(1'b0, COORD_W'(10 * FIX + 64), COORD_W'(6 * FIX), COORD_W'(4 * FIX + 128), "C");
        push_draw(1'b1, COORD_W'(3 * FIX), COORD_W'(8 * FIX), COORD_W'(3 * FIX), "o");
        push_read(9'd5, 9'd5);
        push_read(9'd15, 9'd11);
        push_read(9'd16, 9'd0);
        push_read(9'd0, 9'd12);
        push_read(9'd511, 9'd511);
        push_kind(REQ_NONE);

        run_random_phase(20, 57, 33, 12);
        run_random_phase(57, 20, 33, -1);
        run_random_phase(0, 0, 34, -1);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("circle_canvas_rasterizer_core_tb: clean");
        end else begin
            $display("circle_canvas_rasterizer_core_tb: errors");
        end
        $finish;
    end

endmodule
